/* rtl/core/cds_pkg.sv */
// shared types and sequencer states for the diophantine solution counter
package cds_pkg;

	typedef struct packed {
		logic signed [31:0] coef_a;
		logic signed [31:0] coef_b;
		logic signed [31:0] coef_c;
		logic signed [31:0] x_lo;
		logic signed [31:0] x_hi;
		logic signed [31:0] y_lo;
		logic signed [31:0] y_hi;
	} cds_in_t;

	typedef struct packed {
		logic [63:0] solution_count;
		logic [31:0] gcd_value;
		logic        solvable;
	} cds_out_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_CASE,
		S_AREA,
		S_AREA2,
		S_AXDIV,
		S_EDIV,
		S_EMS,
		S_ES,
		S_EMT,
		S_ET,
		S_CDIV,
		S_MX,
		S_MY,
		S_DA,
		S_DB,
		S_K1,
		S_K2,
		S_K3,
		S_K4,
		S_FIN,
		S_OUT
	} cds_state_t;

	localparam int DivSteps = 64;

endpackage

/* rtl/core/cds_div.sv */
// serial restoring divider: signed 64-bit dividend by positive 33-bit divisor, C truncation
module cds_div import cds_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [63:0] n,
	input  logic        [32:0] d,
	output logic               done,
	output logic signed [63:0] q,
	output logic signed [63:0] r
);

	logic        busy_q;
	logic        done_q;
	logic [6:0]  cnt_q;
	logic [63:0] nq_q;
	logic [32:0] rem_q;
	logic [32:0] d_q;
	logic        sn_q;
	logic [33:0] trial;
	logic        fits;

	assign trial = {rem_q, nq_q[63]};
	assign fits  = trial >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'(DivSteps);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			nq_q  <= n[63] ? 64'(-n) : 64'(n);
			sn_q  <= n[63];
			d_q   <= d;
			rem_q <= '0;
		end else if (busy_q) begin
			// quotient bits shift in where dividend bits leave
			rem_q <= fits ? 33'(trial - {1'b0, d_q}) : trial[32:0];
			nq_q  <= {nq_q[62:0], fits};
		end
	end

	assign done = done_q;
	assign q    = sn_q ? -$signed(nq_q) : $signed(nq_q);
	assign r    = sn_q ? -$signed({31'd0, rem_q}) : $signed({31'd0, rem_q});

endmodule

/* rtl/core/count_diophantine_solutions_in_box_core.sv */
// top level: extended euclid and box count sequencer around a shared divider and multiplier
//
//  channel   signals              direction  beat
//  command   start, busy, cmd     in         start & !busy
//  result    done, result         out        done, one cycle, no stall
//
// each euclid step is a serial divide followed by the s, t update in S_EMS, S_ES, S_EMT and S_ET,
// and the seven closing divisions follow; the 64-step serial divider dominates the run time
// busy rises in the cycle after the accepted beat and stays high through the done cycle
// reset clears the sequencer and divider control only; there is no stored state between items
// the result receiver cannot stall, so done is a single-cycle strobe
module count_diophantine_solutions_in_box_core import cds_pkg::*; #(
	parameter int COORD_WIDTH = 32
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  cds_in_t  cmd,
	output logic     done,
	output cds_out_t result
);

	cds_state_t state_q, state_d;

	logic signed [63:0] a_q, b_q, c_q, xl_q, xh_q, yl_q, yh_q;
	logic signed [63:0] r0_q, r1_q, s0_q, s1_q, t0_q, t1_q, qe_q, prod_q;
	logic signed [63:0] x0_q, y0_q, ca_q, cb_q, klo_q, khi_q;
	logic        [67:0] area_q;
	logic        [63:0] count_q;
	logic        [31:0] g_q;
	logic               ok_q;
	logic               issued_q;

	logic               is_div;
	logic               div_start, div_done;
	logic signed [63:0] div_n, div_q, div_r;
	logic        [32:0] div_d;
	logic signed [33:0] mul_a, mul_b;
	logic signed [67:0] mul_p;
	logic signed [63:0] ceil_v, floor_v, axv;

	function automatic logic signed [63:0] ext(input logic [31:0] v);
		return 64'($signed(v[COORD_WIDTH-1:0]));
	endfunction

	function automatic logic [63:0] span(input logic signed [63:0] lo, input logic signed [63:0] hi);
		return (lo > hi) ? 64'd0 : 64'(hi - lo + 64'sd1);
	endfunction

	function automatic logic signed [63:0] absv(input logic signed [63:0] v);
		return v[63] ? -v : v;
	endfunction

	cds_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.n      (div_n),
		.d      (div_d),
		.done   (div_done),
		.q      (div_q),
		.r      (div_r)
	);

	assign ceil_v  = div_q + ((div_r > 64'sd0) ? 64'sd1 : 64'sd0);
	assign floor_v = div_q - ((div_r < 64'sd0) ? 64'sd1 : 64'sd0);
	// -c/b or -c/a from c/|b| or c/|a|
	assign axv     = (a_q == 64'sd0) ? (b_q[63] ? div_q : -div_q) : (a_q[63] ? div_q : -div_q);

	always_comb begin
		is_div = 1'b0;
		div_n  = c_q;
		div_d  = r0_q[32:0];
		mul_a  = qe_q[33:0];
		mul_b  = s1_q[33:0];
		case (state_q)
			S_AXDIV: begin
				is_div = 1'b1;
				div_d  = (a_q == 64'sd0) ? 33'(absv(b_q)) : 33'(absv(a_q));
			end
			S_EDIV: begin
				is_div = (r1_q != 64'sd0);
				div_n  = r0_q;
				div_d  = r1_q[32:0];
			end
			S_CDIV: is_div = 1'b1;
			S_DA: begin
				is_div = 1'b1;
				div_n  = a_q;
			end
			S_DB: begin
				is_div = 1'b1;
				div_n  = b_q;
			end
			S_K1: begin
				is_div = 1'b1;
				div_n  = xl_q - x0_q;
				div_d  = cb_q[32:0];
			end
			S_K2: begin
				is_div = 1'b1;
				div_n  = xh_q - x0_q;
				div_d  = cb_q[32:0];
			end
			S_K3: begin
				is_div = 1'b1;
				div_n  = ca_q[63] ? (yl_q - y0_q) : (y0_q - yh_q);
				div_d  = 33'(absv(ca_q));
			end
			S_K4: begin
				is_div = 1'b1;
				div_n  = ca_q[63] ? (yh_q - y0_q) : (y0_q - yl_q);
				div_d  = 33'(absv(ca_q));
			end
			S_EMT:   mul_b = t1_q[33:0];
			S_MX:    mul_b = a_q[63] ? -s0_q[33:0] : s0_q[33:0];
			S_MY:    mul_b = b_q[63] ? -t0_q[33:0] : t0_q[33:0];
			S_AREA: begin
				mul_a = $signed({1'b0, 33'(span(xl_q, xh_q))});
				mul_b = $signed({1'b0, 33'(span(yl_q, yh_q))});
			end
			default: ;
		endcase
	end

	assign mul_p     = mul_a * mul_b;
	assign div_start = is_div && !issued_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:  if (start) state_d = S_CASE;
			S_CASE: begin
				if (a_q == 64'sd0 && b_q == 64'sd0)
					state_d = (c_q == 64'sd0) ? S_AREA : S_OUT;
				else if (a_q == 64'sd0 || b_q == 64'sd0)
					state_d = S_AXDIV;
				else
					state_d = S_EDIV;
			end
			S_AREA:  state_d = S_AREA2;
			S_AREA2: state_d = S_OUT;
			S_AXDIV: if (div_done) state_d = S_OUT;
			S_EDIV: begin
				if (!issued_q && r1_q == 64'sd0) state_d = S_CDIV;
				else if (div_done) state_d = S_EMS;
			end
			S_EMS:   state_d = S_ES;
			S_ES:    state_d = S_EMT;
			S_EMT:   state_d = S_ET;
			S_ET:    state_d = S_EDIV;
			S_CDIV:  if (div_done) state_d = (div_r != 64'sd0) ? S_OUT : S_MX;
			S_MX:    state_d = S_MY;
			S_MY:    state_d = S_DA;
			S_DA:    if (div_done) state_d = S_DB;
			S_DB:    if (div_done) state_d = S_K1;
			S_K1:    if (div_done) state_d = S_K2;
			S_K2:    if (div_done) state_d = S_K3;
			S_K3:    if (div_done) state_d = S_K4;
			S_K4:    if (div_done) state_d = S_FIN;
			S_FIN:   state_d = S_OUT;
			S_OUT:   state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			issued_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (div_done)
				issued_q <= 1'b0;
			else if (div_start)
				issued_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				a_q     <= ext(cmd.coef_a);
				b_q     <= ext(cmd.coef_b);
				c_q     <= ext(cmd.coef_c);
				xl_q    <= ext(cmd.x_lo);
				xh_q    <= ext(cmd.x_hi);
				yl_q    <= ext(cmd.y_lo);
				yh_q    <= ext(cmd.y_hi);
			end
			S_CASE: begin
				count_q <= '0;
				ok_q    <= 1'b0;
				g_q     <= (a_q == 64'sd0) ? 32'(absv(b_q)) : 32'(absv(a_q));
				r0_q    <= absv(a_q);
				r1_q    <= absv(b_q);
				s0_q    <= 64'sd1;
				s1_q    <= 64'sd0;
				t0_q    <= 64'sd0;
				t1_q    <= 64'sd1;
			end
			S_AREA:  area_q <= 68'(mul_p);
			S_AREA2: begin
				ok_q    <= 1'b1;
				count_q <= (area_q[67:64] != 4'd0) ? '1 : area_q[63:0];
			end
			S_AXDIV: begin
				if (div_done && div_r == 64'sd0) begin
					ok_q <= 1'b1;
					if (a_q == 64'sd0)
						count_q <= (yl_q <= axv && axv <= yh_q) ? span(xl_q, xh_q) : '0;
					else
						count_q <= (xl_q <= axv && axv <= xh_q) ? span(yl_q, yh_q) : '0;
				end
			end
			S_EDIV: begin
				if (div_done) begin
					qe_q <= div_q;
					r0_q <= r1_q;
					r1_q <= div_r;
				end
			end
			S_EMS, S_EMT: prod_q <= 64'(mul_p);
			S_ES: begin
				s0_q <= s1_q;
				s1_q <= s0_q - prod_q;
			end
			S_ET: begin
				t0_q <= t1_q;
				t1_q <= t0_q - prod_q;
			end
			S_CDIV: begin
				g_q <= r0_q[31:0];
				if (div_done) begin
					qe_q <= -div_q;
					ok_q <= (div_r == 64'sd0);
				end
			end
			S_MX: x0_q <= 64'(mul_p);
			S_MY: y0_q <= 64'(mul_p);
			S_DA: if (div_done) ca_q <= div_q;
			S_DB: begin
				// normalize so the x step is positive
				if (div_done) begin
					cb_q <= absv(div_q);
					ca_q <= div_q[63] ? -ca_q : ca_q;
				end
			end
			S_K1: if (div_done) klo_q <= ceil_v;
			S_K2: if (div_done) khi_q <= floor_v;
			S_K3: if (div_done && ceil_v > klo_q) klo_q <= ceil_v;
			S_K4: if (div_done && floor_v < khi_q) khi_q <= floor_v;
			S_FIN: count_q <= span(klo_q, khi_q);
			default: ;
		endcase
	end

	assign busy                  = (state_q != S_IDLE);
	assign done                  = (state_q == S_OUT);
	assign result.solution_count = count_q;
	assign result.gcd_value      = g_q;
	assign result.solvable       = ok_q;

endmodule
